// ----- rtl/mfd_pkg.sv -----
// Shared constants and types of the motor failure detector.
package mfd_pkg;

    localparam int MOTORS   = 8;
    localparam int CHANNELS = (MOTORS < 8) ? MOTORS : 8;
    localparam int IDX_W    = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int PWM_W    = 12;
    localparam int LVL_W    = 16;
    localparam int TIME_W   = 32;
    localparam int SUM_W    = LVL_W + $clog2(MOTORS);
    localparam int CNT_W    = $clog2(MOTORS + 1);
    // step counter of the average divider
    localparam int BIT_W    = $clog2(SUM_W);

    localparam logic [LVL_W-1:0] LVL_FULL = '1;

    // stream beat layout, lowest bit first
    localparam int IN_ARMED  = 0;
    localparam int IN_TIME   = 1;
    localparam int IN_PWM0   = IN_TIME + TIME_W;
    localparam int IN_BITS   = IN_PWM0 + 8 * PWM_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_REQ    = 0;
    localparam int OUT_MET    = 1;
    localparam int OUT_IDX    = 2;
    localparam int OUT_IDX_W  = 3;
    localparam int OUT_HI     = OUT_IDX + OUT_IDX_W;
    localparam int OUT_AVG    = OUT_HI + LVL_W;
    localparam int OUT_BITS   = OUT_AVG + LVL_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PWM_MIN,
        REG_PWM_MAX,
        REG_MOTOR_MASK,
        REG_FILTER_ALPHA,
        REG_HIGH_THR,
        REG_AVG_THR,
        REG_DETECT_MS,
        REG_HOLDOFF_MS
    } t_cfg_reg;

    // filter register update applied at the end of the scaling phase
    typedef enum logic [1:0] {
        UPD_CLEAR,
        UPD_LOAD,
        UPD_FILTER
    } t_upd_mode;

    typedef struct packed {
        logic            start;
        logic            upd;
        t_upd_mode       mode;
    } t_lane_ctl;

    typedef struct packed {
        logic [PWM_W-1:0] pwm_min;
        logic [PWM_W-1:0] pwm_max;
        logic [LVL_W-1:0] alpha;
    } t_lane_cfg;

    typedef struct packed {
        logic             any;
        logic [IDX_W-1:0] hi_idx;
        logic [LVL_W-1:0] hi_lvl;
        logic [LVL_W-1:0] avg;
    } t_merge_res;

endpackage

// ----- rtl/motor_failure_detector.sv -----
// Top level of the motor failure detector: registers, sequencer, decision and output stage.
//
// One input beat per control tick: armed flag, millisecond time and eight PWM words.
// One output beat per input beat: recovery request, criteria flag, highest channel,
// highest filtered level and average filtered level (levels unsigned Q0.16).
// Configuration goes through a plain write port (i_cfg_we / i_cfg_addr / i_cfg_data);
// it is to be written only while no tick is in flight; the block itself does not enforce this.
// Timing: every lane scales its PWM word with a two-bit-per-clock divider, the filters
// then update, then the merge stage scans the MOTORS lanes one per clock and divides
// the sum by the enabled count one bit per clock. On a disarmed or hold-off tick the
// merge stage is skipped and an all-zero result follows the filter update.
// s_axis_tready rises again in the clock after the result is latched, so the block
// takes no new tick while one is in flight.
// The result waits in an output register; a stalled receiver holds it and the next
// tick is still accepted and worked, stalling only when its own result is ready.
// Reset (synchronous, active low) restores the register defaults, clears the filters,
// the fail and recovery timers and the last highest channel, and empties the output.
module motor_failure_detector import mfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // armed[0], time_ms[32:1], pwm_0[44:33] ... pwm_7[128:117], zero fill
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // recovery_request[0], criteria_met[1], highest_index[4:2],
    // highest_level[20:5], average_level[36:21], zero fill
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_addr,
    input  logic [15:0]           i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_UPDATE,
        S_MSTART,
        S_MERGE,
        S_DECIDE,
        S_OUT
    } t_state;

    // configuration
    logic [PWM_W-1:0]  r_pwm_min;
    logic [PWM_W-1:0]  r_pwm_max;
    logic [7:0]        r_mask;
    logic [LVL_W-1:0]  r_alpha;
    logic [LVL_W-1:0]  r_high_thr;
    logic [LVL_W-1:0]  r_avg_thr;
    logic [15:0]       r_detect;
    logic [15:0]       r_holdoff;

    // tick state
    t_state            r_state;
    logic              r_armed;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_fail_start;
    logic [TIME_W-1:0] r_rec_start;
    logic [IDX_W-1:0]  r_prev;

    // pending result and output stage
    logic              r_res_req;
    logic              r_res_met;
    logic [OUT_IDX_W-1:0] r_res_idx;
    logic [LVL_W-1:0]  r_res_hi;
    logic [LVL_W-1:0]  r_res_avg;
    logic              r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic              accept;
    t_lane_ctl         lane_ctl;
    t_lane_cfg         lane_cfg;
    logic [MOTORS-1:0][PWM_W-1:0] lane_pwm;
    logic [MOTORS-1:0] lane_en;
    logic [MOTORS-1:0] lane_busy;
    logic [MOTORS-1:0][LVL_W-1:0] lane_filt;
    logic              merge_start;
    logic              merge_busy;
    t_merge_res        merge_res;
    logic              in_holdoff;
    t_upd_mode         upd_mode;
    logic              met;
    logic              req;
    logic              out_free;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_m_valid || m_axis_tready;

    always_comb begin
        in_holdoff = ((r_now - r_rec_start) <= TIME_W'(r_holdoff));
        if (!r_armed) begin
            upd_mode = UPD_CLEAR;
        end else if (in_holdoff) begin
            upd_mode = UPD_LOAD;
        end else begin
            upd_mode = UPD_FILTER;
        end
        met = merge_res.any && (merge_res.hi_idx == r_prev) &&
              (merge_res.hi_lvl >= r_high_thr) && (merge_res.avg <= r_avg_thr);
        req = met && ((r_now - r_fail_start) > TIME_W'(r_detect));

        lane_ctl.start   = accept;
        lane_ctl.upd     = (r_state == S_UPDATE);
        lane_ctl.mode    = upd_mode;
        lane_cfg.pwm_min = r_pwm_min;
        lane_cfg.pwm_max = r_pwm_max;
        lane_cfg.alpha   = r_alpha;
        merge_start      = (r_state == S_MSTART);
    end

    // lanes beyond the eight PWM inputs stay disabled
    for (genvar g = 0; g < MOTORS; g++) begin : g_lane
        if (g < CHANNELS) begin : g_wired
            assign lane_pwm[g] = s_axis_tdata[IN_PWM0 + g*PWM_W +: PWM_W];
            assign lane_en[g]  = r_mask[g];
        end else begin : g_unused
            assign lane_pwm[g] = '0;
            assign lane_en[g]  = 1'b0;
        end

        mfd_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_cfg   (lane_cfg),
            .i_pwm   (lane_pwm[g]),
            .i_en    (lane_en[g]),
            .o_busy  (lane_busy[g]),
            .o_filt  (lane_filt[g])
        );
    end

    mfd_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (merge_start),
        .i_filt  (lane_filt),
        .i_en    (lane_en),
        .o_busy  (merge_busy),
        .o_res   (merge_res)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_min  <= PWM_W'(1000);
            r_pwm_max  <= PWM_W'(2000);
            r_mask     <= 8'd15;
            r_alpha    <= LVL_W'(4777);
            r_high_thr <= LVL_W'(62259);
            r_avg_thr  <= LVL_W'(50463);
            r_detect   <= 16'd200;
            r_holdoff  <= 16'd1250;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_PWM_MIN:      r_pwm_min  <= i_cfg_data[PWM_W-1:0];
                REG_PWM_MAX:      r_pwm_max  <= i_cfg_data[PWM_W-1:0];
                REG_MOTOR_MASK:   r_mask     <= i_cfg_data[7:0];
                REG_FILTER_ALPHA: r_alpha    <= i_cfg_data;
                REG_HIGH_THR:     r_high_thr <= i_cfg_data;
                REG_AVG_THR:      r_avg_thr  <= i_cfg_data;
                REG_DETECT_MS:    r_detect   <= i_cfg_data;
                REG_HOLDOFF_MS:   r_holdoff  <= i_cfg_data;
                default:          r_detect   <= r_detect;
            endcase
        end
    end

    // tick sequencer, detector state and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_armed      <= 1'b0;
            r_now        <= '0;
            r_fail_start <= '0;
            r_rec_start  <= '0;
            r_prev       <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            // in S_OUT a new result takes the place of the one leaving
            if (r_m_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_armed <= s_axis_tdata[IN_ARMED];
                        r_now   <= s_axis_tdata[IN_TIME +: TIME_W];
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (lane_busy == '0) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    // lanes take upd_mode this cycle
                    if (upd_mode == UPD_FILTER) begin
                        r_state <= S_MSTART;
                    end else begin
                        r_fail_start <= r_now;
                        r_res_req    <= 1'b0;
                        r_res_met    <= 1'b0;
                        r_res_idx    <= '0;
                        r_res_hi     <= '0;
                        r_res_avg    <= '0;
                        r_state      <= S_OUT;
                    end
                end
                S_MSTART: r_state <= S_MERGE;
                S_MERGE: begin
                    if (!merge_busy) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (!met) begin
                        r_fail_start <= r_now;
                    end
                    if (req) begin
                        r_rec_start <= r_now;
                    end
                    r_prev    <= merge_res.hi_idx;
                    r_res_req <= req;
                    r_res_met <= met;
                    r_res_idx <= OUT_IDX_W'(merge_res.hi_idx);
                    r_res_hi  <= merge_res.hi_lvl;
                    r_res_avg <= merge_res.avg;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= OUT_DATA_W'({r_res_avg, r_res_hi, r_res_idx,
                                                  r_res_met, r_res_req});
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // no work in flight while a new beat can be taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (lane_busy == '0) && !merge_busy)
        else $error("input ready while lanes or merge busy");

    // lanes and merge stage never run at the same time
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_busy != '0) |-> !merge_busy)
        else $error("merge stage running during scaling");

    // a recovery is only ever asked together with the criteria
    a_req_met: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_REQ] |-> m_axis_tdata[OUT_MET])
        else $error("recovery request without criteria");

    // an accepted beat closes the input until its result is latched
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("second beat accepted while a tick is in flight");

endmodule

// ----- rtl/mfd_lane.sv -----
// One motor lane: PWM-to-level scaling divider and low-pass filter register.
module mfd_lane import mfd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lane_ctl        i_ctl,
    input  t_lane_cfg        i_cfg,
    input  logic [PWM_W-1:0] i_pwm,
    input  logic             i_en,
    output logic             o_busy,
    output logic [LVL_W-1:0] o_filt
);

    typedef enum logic [1:0] {
        K_ZERO,
        K_FULL,
        K_DIV
    } t_kind;

    t_kind              r_kind;
    logic               r_busy;
    logic [2:0]         r_step;
    logic [PWM_W-1:0]   r_rem;
    logic [PWM_W-1:0]   r_div;
    logic [LVL_W-1:0]   r_num;      // dividend low bits, quotient shifts in from below
    logic [LVL_W-1:0]   r_filt;

    t_kind              n_kind;
    logic [PWM_W-1:0]   diff;
    logic [PWM_W+LVL_W-1:0] num;
    logic [PWM_W:0]     rem_a;
    logic [PWM_W:0]     rem_b;
    logic [PWM_W-1:0]   rem_a2;
    logic [PWM_W-1:0]   rem_b2;
    logic               q_a;
    logic               q_b;
    logic [LVL_W-1:0]   level;
    logic               up;
    logic [LVL_W-1:0]   gap;
    logic [2*LVL_W-1:0] prod;
    logic [LVL_W-1:0]   mag;
    logic [LVL_W-1:0]   filt_step;

    always_comb begin
        if (!i_en || (i_pwm <= i_cfg.pwm_min)) begin
            n_kind = K_ZERO;
        end else if (i_pwm >= i_cfg.pwm_max) begin
            n_kind = K_FULL;
        end else begin
            n_kind = K_DIV;
        end
        diff = i_pwm - i_cfg.pwm_min;
        // diff * 65535
        num  = {diff, {LVL_W{1'b0}}} - {{LVL_W{1'b0}}, diff};

        // two restoring steps per clock
        rem_a  = {r_rem, r_num[LVL_W-1]};
        q_a    = (rem_a >= {1'b0, r_div});
        rem_a2 = q_a ? PWM_W'(rem_a - {1'b0, r_div}) : rem_a[PWM_W-1:0];
        rem_b  = {rem_a2, r_num[LVL_W-2]};
        q_b    = (rem_b >= {1'b0, r_div});
        rem_b2 = q_b ? PWM_W'(rem_b - {1'b0, r_div}) : rem_b[PWM_W-1:0];

        case (r_kind)
            K_ZERO:  level = '0;
            K_FULL:  level = LVL_FULL;
            K_DIV:   level = r_num;
            default: level = '0;
        endcase

        // f += round((level - f) * alpha / 2^16), halves away from zero
        up        = (level >= r_filt);
        gap       = up ? (level - r_filt) : (r_filt - level);
        prod      = gap * i_cfg.alpha + (2*LVL_W)'(32'h0000_8000);
        mag       = prod[2*LVL_W-1:LVL_W];
        filt_step = up ? (r_filt + mag) : (r_filt - mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_kind <= K_ZERO;
            r_filt <= '0;
        end else begin
            if (i_ctl.start) begin
                r_kind <= n_kind;
                r_rem  <= num[PWM_W+LVL_W-1:LVL_W];
                r_num  <= num[LVL_W-1:0];
                r_div  <= i_cfg.pwm_max - i_cfg.pwm_min;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= rem_b2;
                r_num  <= {r_num[LVL_W-3:0], q_a, q_b};
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_ctl.upd) begin
                case (i_ctl.mode)
                    UPD_CLEAR:  r_filt <= '0;
                    UPD_LOAD:   r_filt <= level;
                    UPD_FILTER: r_filt <= filt_step;
                    default:    r_filt <= r_filt;
                endcase
            end
        end
    end

    assign o_busy = r_busy;
    assign o_filt = r_filt;

endmodule

// ----- rtl/mfd_merge.sv -----
// Merging stage: scan of the lane levels for maximum and sum, then the average divider.
module mfd_merge import mfd_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [MOTORS-1:0][LVL_W-1:0] i_filt,
    input  logic [MOTORS-1:0]            i_en,
    output logic                         o_busy,
    output t_merge_res                   o_res
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_SCAN,
        M_DIV
    } t_mstate;

    t_mstate           r_state;
    logic [IDX_W-1:0]  r_idx;
    logic [BIT_W-1:0]  r_bit;
    logic [IDX_W-1:0]  r_hi_idx;
    logic [LVL_W-1:0]  r_hi;
    logic [SUM_W-1:0]  r_sum;      // becomes the quotient during M_DIV
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_rem;

    logic [LVL_W-1:0]  cur;
    logic [CNT_W:0]    rem2;
    logic              q;

    always_comb begin
        cur  = i_filt[r_idx];
        rem2 = {r_rem, r_sum[SUM_W-1]};
        q    = (rem2 >= {1'b0, r_cnt});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_idx   <= '0;
            r_bit   <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_idx    <= '0;
                        r_hi     <= '0;
                        r_hi_idx <= '0;
                        r_sum    <= '0;
                        r_cnt    <= '0;
                        r_state  <= M_SCAN;
                    end
                end
                M_SCAN: begin
                    if (i_en[r_idx]) begin
                        if (cur > r_hi) begin
                            r_hi     <= cur;
                            r_hi_idx <= r_idx;
                        end
                        r_sum <= r_sum + SUM_W'(cur);
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (r_idx == IDX_W'(MOTORS - 1)) begin
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_state <= M_DIV;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                M_DIV: begin
                    r_rem <= q ? CNT_W'(rem2 - {1'b0, r_cnt}) : rem2[CNT_W-1:0];
                    r_sum <= {r_sum[SUM_W-2:0], q};
                    r_bit <= r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(SUM_W - 1)) begin
                        r_state <= M_IDLE;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_busy       = (r_state != M_IDLE);
    assign o_res.any    = (r_cnt != '0);
    assign o_res.hi_idx = r_hi_idx;
    assign o_res.hi_lvl = r_hi;
    assign o_res.avg    = (r_cnt != '0) ? r_sum[LVL_W-1:0] : '0;

endmodule
